[sv/acpg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acpg_pkg
// Shared codes, sequencer states and fixed widths of the profile generator.
// ----------------------------------------------------------------------------
package acpg_pkg;

	localparam int VEL_W = 24;
	localparam int POS_W = 32;

	typedef enum logic [1:0] {
		ACT_SET_POS = 2'd0,
		ACT_MOVE    = 2'd1,
		ACT_TICK    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_ACCEL  = 2'd0,
		STAT_CRUISE = 2'd1,
		STAT_ACCEPT = 2'd2,
		STAT_REJECT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD_DIV,
		S_MUL_LO,
		S_MUL_HI,
		S_DIV_V,
		S_DIV_S,
		S_FIN,
		S_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	// Handshake between the sequencer and the shared divider.
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage
`default_nettype wire

[sv/acpg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acpg_in_if / acpg_out_if
// Valid/ready channels for commands and ticks in, and samples out.
// ----------------------------------------------------------------------------
interface acpg_in_if #(
	parameter int DURATION_BITS = 20
) ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic signed [31:0]       target_position;
	logic signed [23:0]       cruise_velocity;
	logic [DURATION_BITS-1:0] move_duration;

	modport source (
		output valid, action, target_position, cruise_velocity, move_duration,
		input  ready
	);
	modport sink (
		input  valid, action, target_position, cruise_velocity, move_duration,
		output ready
	);
endinterface

interface acpg_out_if #(
	parameter int DURATION_BITS = 20
) ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [DURATION_BITS-1:0] elapsed_ms;
	logic signed [23:0]       velocity;
	logic signed [31:0]       displacement;
	logic                     last_sample;

	modport source (
		output valid, status, elapsed_ms, velocity, displacement, last_sample,
		input  ready
	);
	modport sink (
		input  valid, status, elapsed_ms, velocity, displacement, last_sample,
		output ready
	);
endinterface
`default_nettype wire

[sv/accel_cruise_profile_generator_core.sv]
`default_nettype none
// Set position and ignored items offer no sample and leave the sequencer idle. After the input
// transfer, a command refused while busy or at zero speed goes straight to S_EMIT, any other
// command first waits in S_CMD_DIV for one division, a cruise tick passes through S_FIN, and an
// accel tick runs S_MUL_LO, S_MUL_HI, S_DIV_V, S_DIV_S and S_FIN, using the one-bit-per-cycle
// shared divider twice. The next item can be taken while a sample waits in the output register.
// Reset is asynchronous, active low, and leaves the block idle at position 0.
// ----------------------------------------------------------------------------
// accel_cruise_profile_generator_core
// Single-axis acceleration/cruise motion profile: a small sequencer drives one
// shared divider and a narrow multiplier to produce one sample per tick of a running move.
// ----------------------------------------------------------------------------
module accel_cruise_profile_generator_core #(
	parameter int DURATION_BITS = 20
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	acpg_in_if.sink    req,
	acpg_out_if.source rsp
);
	import acpg_pkg::*;

	localparam int DB  = DURATION_BITS;
	localparam int DW  = 2 * DB + 23;
	localparam int VW  = (DB + 1 > VEL_W) ? DB + 1 : VEL_W;
	localparam int PW  = DB + 25;
	localparam int NSW = ((DB + 26 > 34) ? DB + 26 : 34) + 1;

	seq_state_t state_q, state_d;

	logic                    busy_q;
	logic signed [POS_W-1:0] cur_pos_q;
	logic signed [POS_W-1:0] tgt_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [DB-1:0]           len_q;
	logic [DB-1:0]           ta_q;
	logic [DB-1:0]           tick_q;
	logic signed [NSW-1:0]   num_q;
	logic                    accel_q;
	logic [PW-1:0]           p_q;
	logic [DW-1:0]           prod_q;
	logic [VEL_W-1:0]        vm_q;
	logic [DW-1:0]           sm_q;

	status_t                 res_status_q;
	logic [DB-1:0]           res_elapsed_q;
	logic signed [VEL_W-1:0] res_vel_q;
	logic signed [POS_W-1:0] res_disp_q;
	logic                    res_last_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [DB-1:0]           out_elapsed_q;
	logic signed [VEL_W-1:0] out_vel_q;
	logic signed [POS_W-1:0] out_disp_q;
	logic                    out_last_q;

	logic req_ready;
	logic take;
	logic out_free;
	logic vel_in_zero;

	div_req_t      div_req;
	div_rsp_t      div_rsp;
	logic [DW-1:0] div_dvd;
	logic [VW-1:0] div_dvs;
	logic [DW-1:0] div_quo;

	logic signed [DB+24:0]   prod_dv;
	logic signed [POS_W:0]   pos_diff;
	logic signed [NSW-1:0]   num_c;
	logic signed [NSW-1:0]   num_neg_c;
	logic [NSW-2:0]          num_mag;
	logic [VEL_W-1:0]        vel_mag;
	logic                    cmd_ok;
	logic                    tick_accel;
	logic [DB:0]             tick_factor;
	logic [PW-1:0]           p_c;
	logic [31+DB:0]          pp_lo;
	logic [2*DB-8:0]         pp_hi;
	logic [DW-1:0]           sm_c;
	logic signed [POS_W-1:0] disp_c;
	logic signed [VEL_W-1:0] vsample_c;
	logic                    last_c;

	assign take        = req.valid && req_ready;
	assign req.ready   = req_ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign vel_in_zero = (req.cruise_velocity == '0);

	// Command numerator 2*T*V - 2*(P - position); its quotient by V is the accel time.
	assign prod_dv  = $signed({1'b0, req.move_duration}) * req.cruise_velocity;
	assign pos_diff = $signed({req.target_position[POS_W-1], req.target_position})
	                - $signed({cur_pos_q[POS_W-1], cur_pos_q});
	assign num_c    = ({{(NSW-DB-25){prod_dv[DB+24]}}, prod_dv} <<< 1)
	                - ({{(NSW-POS_W-1){pos_diff[POS_W]}}, pos_diff} <<< 1);

	assign num_neg_c = -num_q;
	assign num_mag   = num_q[NSW-1] ? num_neg_c[NSW-2:0] : num_q[NSW-2:0];
	assign vel_mag   = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);

	// The truncated quotient is positive only when numerator and velocity share a sign.
	assign cmd_ok = (num_q[NSW-1] == vel_q[VEL_W-1]) && (div_quo != '0)
	             && (div_quo <= DW'(len_q));

	assign tick_accel  = (tick_q <= ta_q);
	assign tick_factor = tick_accel ? {1'b0, tick_q} : ({tick_q, 1'b0} - {1'b0, ta_q});
	assign p_c         = vel_mag * tick_factor;

	assign pp_lo = p_q[31:0] * tick_q;
	assign pp_hi = p_q[PW-1:32] * tick_q;

	// In cruise the displacement is V*(2t - ta)/2, already formed in p_q.
	assign sm_c = accel_q ? sm_q : DW'(p_q >> 1);

	always_comb begin
		if (!vel_q[VEL_W-1]) begin
			if (|sm_c[DW-1:31]) disp_c = 32'sh7FFF_FFFF;
			else                disp_c = $signed(sm_c[31:0]);
		end else begin
			if (|sm_c[DW-1:32] || (sm_c[31] && |sm_c[30:0])) disp_c = 32'sh8000_0000;
			else                                            disp_c = -$signed(sm_c[31:0]);
		end
	end

	assign vsample_c = accel_q ? (vel_q[VEL_W-1] ? -$signed(vm_q) : $signed(vm_q)) : vel_q;
	assign last_c    = (tick_q >= len_q);

	acpg_div #(
		.DIVIDEND_W (DW),
		.DIVISOR_W  (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rsp      (div_rsp),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (req.action)
						ACT_MOVE: state_d = (busy_q || vel_in_zero) ? S_EMIT : S_CMD_DIV;
						ACT_TICK: begin
							if (busy_q) state_d = tick_accel ? S_MUL_LO : S_FIN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CMD_DIV: begin
				if (div_rsp.done) state_d = S_EMIT;
			end
			S_MUL_LO: state_d = S_MUL_HI;
			S_MUL_HI: state_d = S_DIV_V;
			S_DIV_V: begin
				if (div_rsp.done) state_d = S_DIV_S;
			end
			S_DIV_S: begin
				if (div_rsp.done) state_d = S_FIN;
			end
			S_FIN: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: input handshake and divider operand selection.
	always_comb begin
		req_ready     = 1'b0;
		div_req.start = 1'b0;
		div_dvd       = DW'(num_mag);
		div_dvs       = VW'(vel_mag);
		case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_CMD_DIV: div_req.start = 1'b1;
			S_DIV_V: begin
				div_req.start = 1'b1;
				div_dvd       = DW'(p_q);
				div_dvs       = VW'(ta_q);
			end
			S_DIV_S: begin
				div_req.start = 1'b1;
				div_dvd       = prod_q;
				div_dvs       = VW'({ta_q, 1'b0});
			end
			default: begin
				req_ready     = 1'b0;
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			cur_pos_q   <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && take && req.action == ACT_SET_POS && !busy_q) begin
				cur_pos_q <= req.target_position;
			end
			if (state_q == S_CMD_DIV && div_rsp.done && cmd_ok) begin
				busy_q <= 1'b1;
				tick_q <= '0;
			end
			if (state_q == S_FIN) begin
				if (last_c) begin
					busy_q    <= 1'b0;
					cur_pos_q <= tgt_q;
				end else begin
					tick_q <= tick_q + 1'b1;
				end
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take && req.action == ACT_MOVE) begin
					if (!busy_q && !vel_in_zero) begin
						tgt_q <= req.target_position;
						vel_q <= req.cruise_velocity;
						len_q <= req.move_duration;
						num_q <= num_c;
					end
					res_status_q  <= STAT_REJECT;
					res_elapsed_q <= '0;
					res_vel_q     <= '0;
					res_disp_q    <= '0;
					res_last_q    <= 1'b0;
				end
				if (take && req.action == ACT_TICK) begin
					accel_q <= tick_accel;
					p_q     <= p_c;
				end
			end
			S_CMD_DIV: begin
				if (div_rsp.done) begin
					ta_q         <= div_quo[DB-1:0];
					res_status_q <= cmd_ok ? STAT_ACCEPT : STAT_REJECT;
				end
			end
			S_MUL_LO: prod_q <= DW'(pp_lo);
			S_MUL_HI: prod_q <= prod_q + (DW'(pp_hi) << 32);
			S_DIV_V: begin
				if (div_rsp.done) vm_q <= div_quo[VEL_W-1:0];
			end
			S_DIV_S: begin
				if (div_rsp.done) sm_q <= div_quo;
			end
			S_FIN: begin
				res_status_q  <= accel_q ? STAT_ACCEL : STAT_CRUISE;
				res_elapsed_q <= tick_q;
				res_vel_q     <= vsample_c;
				res_disp_q    <= disp_c;
				res_last_q    <= last_c;
			end
			S_EMIT: begin
				if (out_free) begin
					out_status_q  <= res_status_q;
					out_elapsed_q <= res_elapsed_q;
					out_vel_q     <= res_vel_q;
					out_disp_q    <= res_disp_q;
					out_last_q    <= res_last_q;
				end
			end
			default: begin
				res_last_q <= res_last_q;
			end
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.elapsed_ms   = out_elapsed_q;
	assign rsp.velocity     = out_vel_q;
	assign rsp.displacement = out_disp_q;
	assign rsp.last_sample  = out_last_q;

endmodule
`default_nettype wire

[sv/acpg_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acpg_div
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module acpg_div #(
	parameter int DIVIDEND_W = 63,
	parameter int DIVISOR_W  = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire acpg_pkg::div_req_t    req,
	output acpg_pkg::div_rsp_t         rsp,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic      [DIVIDEND_W-1:0] quotient
);
	import acpg_pkg::*;

	localparam int CW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

	div_state_t            state_q, state_d;
	logic [CW-1:0]         cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_diff;
	logic                  sub_ok;

	// The dividend shifts out at the top of quo_q while quotient bits enter below.
	assign rem_sh   = {rem_q, quo_q[DIVIDEND_W-1]};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign sub_ok   = rem_sh >= {1'b0, divisor};

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (req.start) state_d = DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == CW'(DIVIDEND_W - 1)) state_d = DIV_DONE;
			end
			DIV_DONE: state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == DIV_DONE);
		quotient = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DIV_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (state_q == DIV_RUN) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], sub_ok};
			rem_q <= sub_ok ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

endmodule
`default_nettype wire
